[rtl/fplc_pkg.sv]
// fplc_pkg: shared types, codes and constants of the flight phase logger control unit
// no dependencies; imported by every module of the block
package fplc_pkg;

    localparam int CNT_W = 14;
    localparam logic [CNT_W-1:0] MAX_LOGGED = 14'd12000;

    localparam logic [1:0] REG_LAUNCH_DELTA    = 2'd0;
    localparam logic [1:0] REG_LAND_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_MIN_RECORD      = 2'd2;
    localparam logic [1:0] REG_SAMPLE_INTERVAL = 2'd3;

    localparam logic [15:0] RST_LAUNCH_DELTA    = 16'd100;
    localparam logic [15:0] RST_LAND_THRESHOLD  = 16'd30;
    localparam logic [15:0] RST_MIN_RECORD      = 16'd2000;
    localparam logic [15:0] RST_SAMPLE_INTERVAL = 16'd100;

    localparam logic [1:0] OP_POLL     = 2'd0;
    localparam logic [1:0] OP_ARM      = 2'd1;
    localparam logic [1:0] OP_TRANSFER = 2'd2;
    localparam logic [1:0] OP_STOP     = 2'd3;

    localparam logic [1:0] STATUS_NONE     = 2'd0;
    localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
    localparam logic [1:0] STATUS_REFUSED  = 2'd2;

    localparam logic [1:0] MODE_CODE_STANDBY   = 2'd0;
    localparam logic [1:0] MODE_CODE_ARMED     = 2'd1;
    localparam logic [1:0] MODE_CODE_RECORDING = 2'd2;

    typedef enum logic [2:0] {
        MODE_STANDBY   = 3'b001,
        MODE_ARMED     = 3'b010,
        MODE_RECORDING = 3'b100
    } t_mode;

    typedef struct packed {
        logic [15:0]        launch_delta_cm;
        logic signed [15:0] land_threshold_cm;
        logic [15:0]        min_record_ms;
        logic [15:0]        sample_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        now_ms;
        logic signed [23:0] altitude_cm;
    } t_item;

    typedef struct packed {
        logic [1:0]         mode;
        logic               clear_log;
        logic               append_sample;
        logic [31:0]        sample_time_ms;
        logic signed [23:0] sample_altitude_cm;
        logic               transfer_request;
        logic [1:0]         command_status;
        logic [CNT_W-1:0]   samples_logged;
    } t_result;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        case (m)
            MODE_ARMED:     c = MODE_CODE_ARMED;
            MODE_RECORDING: c = MODE_CODE_RECORDING;
            default:        c = MODE_CODE_STANDBY;
        endcase
        return c;
    endfunction

endpackage

[rtl/fplc_cfg_regs.sv]
// fplc_cfg_regs: configuration register file written through the plain write port
// depends on fplc_pkg for the register indexes, reset values and t_cfg
module fplc_cfg_regs
    import fplc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.launch_delta_cm   <= RST_LAUNCH_DELTA;
            r_cfg.land_threshold_cm <= RST_LAND_THRESHOLD;
            r_cfg.min_record_ms     <= RST_MIN_RECORD;
            r_cfg.sample_gap_ms     <= RST_SAMPLE_INTERVAL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LAUNCH_DELTA:    r_cfg.launch_delta_cm   <= i_cfg_data;
                REG_LAND_THRESHOLD:  r_cfg.land_threshold_cm <= i_cfg_data;
                REG_MIN_RECORD:      r_cfg.min_record_ms     <= i_cfg_data;
                REG_SAMPLE_INTERVAL: r_cfg.sample_gap_ms     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/fplc_core.sv]
// fplc_core: flight mode state and the single-pass next-state and result logic
// depends on fplc_pkg; fed from the input register, drives the result register
module fplc_core
    import fplc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    t_mode              r_mode, n_mode;
    logic signed [23:0] r_ref_alt, n_ref_alt;
    logic [31:0]        r_start, n_start;
    logic [31:0]        r_last, n_last;
    logic [CNT_W-1:0]   r_count, n_count;

    logic signed [25:0] climb;
    logic [31:0]        since_last;
    logic [31:0]        elapsed;
    logic               launch;
    logic               spaced;
    logic               landed;
    t_result            res;

    assign climb      = 26'(i_item.altitude_cm) - 26'(r_ref_alt);
    assign launch     = climb > $signed({10'd0, i_cfg.launch_delta_cm});
    assign since_last = i_item.now_ms - r_last;
    assign elapsed    = i_item.now_ms - r_start;
    assign spaced     = since_last >= {16'd0, i_cfg.sample_gap_ms};
    assign landed     = (i_item.altitude_cm <= 24'(i_cfg.land_threshold_cm))
                        && (elapsed > {16'd0, i_cfg.min_record_ms});

    always_comb begin
        n_mode    = r_mode;
        n_ref_alt = r_ref_alt;
        n_start   = r_start;
        n_last    = r_last;
        n_count   = r_count;
        res       = '0;
        case (i_item.op)
            OP_POLL: begin
                if (r_mode == MODE_ARMED && launch) begin
                    n_count       = '0;
                    n_start       = i_item.now_ms;
                    n_last        = '0;
                    res.clear_log = 1'b1;
                    n_mode        = MODE_RECORDING;
                end else if (r_mode == MODE_RECORDING && spaced) begin
                    n_last = i_item.now_ms;
                    if (r_count < MAX_LOGGED) begin
                        res.append_sample      = 1'b1;
                        res.sample_time_ms     = elapsed;
                        res.sample_altitude_cm = i_item.altitude_cm;
                        n_count                = r_count + 1'b1;
                    end
                    if (landed) begin
                        n_mode = MODE_STANDBY;
                    end
                end
            end
            OP_ARM: begin
                if (r_mode == MODE_STANDBY) begin
                    n_ref_alt          = i_item.altitude_cm;
                    n_mode             = MODE_ARMED;
                    res.command_status = STATUS_ACCEPTED;
                end else begin
                    res.command_status = STATUS_REFUSED;
                end
            end
            OP_TRANSFER: begin
                if (r_mode == MODE_STANDBY) begin
                    res.transfer_request = 1'b1;
                    res.command_status   = STATUS_ACCEPTED;
                end else begin
                    res.command_status = STATUS_REFUSED;
                end
            end
            default: begin
                n_mode             = MODE_STANDBY;
                res.command_status = STATUS_ACCEPTED;
            end
        endcase
        res.mode           = mode_code(n_mode);
        res.samples_logged = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_STANDBY;
            r_ref_alt <= '0;
            r_start   <= '0;
            r_last    <= '0;
            r_count   <= '0;
        end else if (i_adv) begin
            r_mode    <= n_mode;
            r_ref_alt <= n_ref_alt;
            r_start   <= n_start;
            r_last    <= n_last;
            r_count   <= n_count;
        end
    end

    assign o_res = res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_LOGGED)
        else $error("sample counter above log size");

    a_clear_starts_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && res.clear_log) |=> (r_mode == MODE_RECORDING && r_count == '0))
        else $error("log clear without recording start");

    a_append_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && res.append_sample) |=> (r_count == $past(r_count) + 1'b1))
        else $error("appended sample not counted");

    a_xfer_standby: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.transfer_request |-> (r_mode == MODE_STANDBY
                                  && res.command_status == STATUS_ACCEPTED))
        else $error("transfer granted outside standby");

endmodule

[rtl/flight_phase_logger_control_unit.sv]
// flight_phase_logger_control_unit: top level with input and result registers
// depends on fplc_pkg, fplc_cfg_regs and fplc_core
//
// usage: one stream word in (poll or command), one result word out per item.
// slave side: s_tuser carries the op code, s_tdata the timestamp and altitude.
// master side: m_tdata carries mode, log flags, sample, transfer and status.
// configuration: i_cfg_we/i_cfg_idx/i_cfg_data write one 16-bit register a
// cycle, to be used only while no item is in flight.
// path: input register, single-pass core logic, then result register.
// throughput: one word per cycle unless m_tready stalls; the state update is a
// single pass of compares and 32-bit subtracts between input and result registers.
// reset: synchronous, active low; mode standby, counters and times zero,
// registers at their defaults, both register stages empty.
// stall: when m_tready is low the result word holds, the input register
// holds one more word, and s_tready drops until the result is taken.
module flight_phase_logger_control_unit
    import fplc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // now_ms[31:0], altitude_cm[55:32]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // mode[1:0], clear_log[2], append_sample[3],
                                   // sample_time_ms[35:4], sample_altitude_cm[59:36],
                                   // transfer_request[60], command_status[62:61],
                                   // samples_logged[76:63], zero[79:77]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cfg    cfg;
    t_result res;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    logic    adv;

    assign adv      = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || adv;

    fplc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    fplc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in.op          <= s_tuser;
            r_in.now_ms      <= s_tdata[31:0];
            r_in.altitude_cm <= s_tdata[55:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {3'b000,
                       r_out.samples_logged,
                       r_out.command_status,
                       r_out.transfer_request,
                       r_out.sample_altitude_cm,
                       r_out.sample_time_ms,
                       r_out.append_sample,
                       r_out.clear_log,
                       r_out.mode};

endmodule
